>>> src/cmlp_pkg.sv
// cmlp_pkg: shared types, codes and helpers of the mapping line parser
// used by the parse stage, the result queue and the top level
package cmlp_pkg;

	// default line limits
	localparam int MAX_CODE_UNITS_DEF = 19;
	localparam int MAX_BYTES_DEF      = 31;

	// result queue depth, room for two parsed items' worth of results in flight
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// code point limits
	localparam logic [20:0] CP_LIMIT = 21'h10FFFF;
	localparam logic [20:0] SURR_LO  = 21'h00D800;
	localparam logic [20:0] SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX  = 21'h00FFFF;

	// characters of the line syntax
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_U    = 8'h55;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_BAR  = 8'h7C;

	// result kinds
	localparam logic [1:0] KIND_CP   = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_SUM  = 2'd2;

	// line status codes
	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_TOO_MANY_CPS = 4'd1;
	localparam logic [3:0] ST_BAD_CP       = 4'd2;
	localparam logic [3:0] ST_CP_RANGE     = 4'd3;
	localparam logic [3:0] ST_NO_CPS       = 4'd4;
	localparam logic [3:0] ST_TOO_MANY_U16 = 4'd5;
	localparam logic [3:0] ST_TOO_MANY_B   = 4'd6;
	localparam logic [3:0] ST_BAD_BYTE     = 4'd7;
	localparam logic [3:0] ST_NO_BYTES     = 4'd8;
	localparam logic [3:0] ST_BAD_FB       = 4'd9;

	localparam logic signed [2:0] FB_NONE = -3'sd1;

	typedef enum logic [3:0] {
		PH_CP_OPEN = 4'd0,
		PH_CP_SEP  = 4'd1,
		PH_CP_U    = 4'd2,
		PH_CP_DIG  = 4'd3,
		PH_WS      = 4'd4,
		PH_B_OPEN  = 4'd5,
		PH_B_SEP   = 4'd6,
		PH_B_X     = 4'd7,
		PH_B_D1    = 4'd8,
		PH_B_D2    = 4'd9,
		PH_B_CHK   = 4'd10,
		PH_SCAN    = 4'd11,
		PH_FB      = 4'd12,
		PH_IDLE    = 4'd13
	} phase_t;

	// parser state carried from item to item
	typedef struct packed {
		phase_t             phase;
		logic [20:0]        cp_acc;
		logic               cp_ovf;
		logic [2:0]         hex_cnt;
		logic [4:0]         cp_cnt;
		logic [5:0]         u16_cnt;
		logic [7:0]         byte_acc;
		logic [4:0]         byte_cnt;
		logic [3:0]         err;
		logic signed [2:0]  fb;
	} parse_state_t;

	// one parsing pass over the current character
	typedef struct packed {
		parse_state_t st;
		logic         again;
		logic         emit;
		logic [1:0]   kind;
		logic [20:0]  value;
	} pass_t;

	// one result item
	typedef struct packed {
		logic [1:0]        kind;
		logic [20:0]       value;
		logic [3:0]        status;
		logic [4:0]        cp_cnt;
		logic [4:0]        byte_cnt;
		logic signed [2:0] fb;
		logic              last;
	} result_t;

	// results written into the queue by one parsed item
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic parse_state_t reset_state();
		parse_state_t s;
		s.phase    = PH_CP_OPEN;
		s.cp_acc   = '0;
		s.cp_ovf   = 1'b0;
		s.hex_cnt  = '0;
		s.cp_cnt   = '0;
		s.u16_cnt  = '0;
		s.byte_acc = '0;
		s.byte_cnt = '0;
		s.err      = ST_OK;
		s.fb       = FB_NONE;
		return s;
	endfunction

	// hex digit decode: {valid, digit}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, c[3:0]};
		else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

endpackage

>>> src/conversion_mapping_line_parser.sv
// Mapping line parser: one character per item, code point, byte and summary results.
// Each character is registered in the input register, its results in the result queue.
// Throughput: one character per cycle while the result queue has room; the result
// port moves one result per cycle, so a line end with two results may hold input.
// Reset: arst_n clears the parser to the start of a line and empties the result queue.
// depends on cmlp_pkg, cmlp_parse, cmlp_outq
module conversion_mapping_line_parser import cmlp_pkg::*; #(
	parameter int MAX_CODE_UNITS = MAX_CODE_UNITS_DEF,
	parameter int MAX_BYTES      = MAX_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [20:0]       value,
	output logic [3:0]        status,
	output logic [4:0]        code_point_count,
	output logic [4:0]        byte_count,
	output logic signed [2:0] fallback,
	output logic              last
);

	push_t   push;
	logic    room;
	result_t head;

	// parse stage
	cmlp_parse #(
		.MAX_CODE_UNITS(MAX_CODE_UNITS),
		.MAX_BYTES(MAX_BYTES)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.room(room),
		.push(push)
	);

	// result queue
	cmlp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	// result fields
	assign kind             = head.kind;
	assign value            = head.value;
	assign status           = head.status;
	assign code_point_count = head.cp_cnt;
	assign byte_count       = head.byte_cnt;
	assign fallback         = head.fb;
	assign last             = head.last;

endmodule

>>> src/cmlp_parse.sv
// cmlp_parse: input register, line parser state and result generation
// depends on cmlp_pkg
module cmlp_parse import cmlp_pkg::*; #(
	parameter int MAX_CODE_UNITS = MAX_CODE_UNITS_DEF,
	parameter int MAX_BYTES      = MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       room,
	output push_t      push
);

	localparam logic [4:0] MCU5 = 5'(MAX_CODE_UNITS);
	localparam logic [5:0] MCU6 = 6'(MAX_CODE_UNITS);
	localparam logic [4:0] MB5  = 5'(MAX_BYTES);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         fire;
	parse_state_t st_q;
	parse_state_t st_d;
	pass_t        p;
	logic         emit;
	logic [1:0]   emit_kind;
	logic [20:0]  emit_value;
	result_t      item_r;
	result_t      sum_r;
	logic         eol;

	// one pass of the parser; again asks for the same character once more
	function automatic pass_t step(input parse_state_t s, input logic [7:0] c);
		pass_t       r;
		logic [4:0]  h;
		logic [24:0] v;
		r.st    = s;
		r.again = 1'b0;
		r.emit  = 1'b0;
		r.kind  = KIND_CP;
		r.value = '0;
		h       = hex_val(c);
		v       = {s.cp_acc, 4'b0} + 25'(h[3:0]);
		case (s.phase)
			PH_CP_OPEN, PH_CP_SEP: begin
				if (s.phase == PH_CP_SEP && c == CH_PLUS) begin
					r.st.phase = PH_CP_OPEN;
				end else if (c == CH_LT) begin
					if (s.cp_cnt >= MCU5) begin
						r.st.err = ST_TOO_MANY_CPS; r.st.phase = PH_IDLE;
					end else begin
						r.st.phase = PH_CP_U;
					end
				end else if (s.cp_cnt == 5'd0) begin
					r.st.err = ST_NO_CPS; r.st.phase = PH_IDLE;
				end else if (s.cp_cnt > 5'd1 && s.u16_cnt > MCU6) begin
					r.st.err = ST_TOO_MANY_U16; r.st.phase = PH_IDLE;
				end else begin
					r.st.phase = PH_WS;
					r.again    = 1'b1;
				end
			end
			PH_CP_U: begin
				if (c == CH_U) begin
					r.st.cp_acc  = '0;
					r.st.cp_ovf  = 1'b0;
					r.st.hex_cnt = '0;
					r.st.phase   = PH_CP_DIG;
				end else begin
					r.st.err = ST_BAD_CP; r.st.phase = PH_IDLE;
				end
			end
			PH_CP_DIG: begin
				if (h[4]) begin
					if (s.hex_cnt < 3'd7)
						r.st.hex_cnt = s.hex_cnt + 3'd1;
					// saturate: keep the last value once past the limit
					if (!s.cp_ovf) begin
						if (v > 25'(CP_LIMIT))
							r.st.cp_ovf = 1'b1;
						else
							r.st.cp_acc = v[20:0];
					end
				end else if (c != CH_GT || s.hex_cnt == 3'd0) begin
					r.st.err = ST_BAD_CP; r.st.phase = PH_IDLE;
				end else if (s.cp_ovf || (s.cp_acc >= SURR_LO && s.cp_acc <= SURR_HI)) begin
					r.st.err = ST_CP_RANGE; r.st.phase = PH_IDLE;
				end else begin
					r.emit       = 1'b1;
					r.kind       = KIND_CP;
					r.value      = s.cp_acc;
					r.st.cp_cnt  = s.cp_cnt + 5'd1;
					r.st.u16_cnt = s.u16_cnt + ((s.cp_acc > BMP_MAX) ? 6'd2 : 6'd1);
					r.st.phase   = PH_CP_SEP;
				end
			end
			PH_WS: begin
				if (c != CH_SP && c != CH_TAB) begin
					r.st.phase = PH_B_OPEN;
					r.again    = 1'b1;
				end
			end
			PH_B_OPEN, PH_B_SEP: begin
				if (s.phase == PH_B_SEP && c == CH_PLUS) begin
					r.st.phase = PH_B_OPEN;
				end else if (c == CH_BSL) begin
					if (s.byte_cnt >= MB5) begin
						r.st.err = ST_TOO_MANY_B; r.st.phase = PH_IDLE;
					end else begin
						r.st.phase = PH_B_X;
					end
				end else if (s.byte_cnt == 5'd0) begin
					r.st.err = ST_NO_BYTES; r.st.phase = PH_IDLE;
				end else begin
					r.st.phase = PH_SCAN;
					r.again    = 1'b1;
				end
			end
			PH_B_X: begin
				if (c == CH_X) begin
					r.st.byte_acc = '0;
					r.st.phase    = PH_B_D1;
				end else begin
					r.st.err = ST_BAD_BYTE; r.st.phase = PH_IDLE;
				end
			end
			PH_B_D1, PH_B_D2: begin
				if (!h[4]) begin
					r.st.err = ST_BAD_BYTE; r.st.phase = PH_IDLE;
				end else begin
					r.st.byte_acc = {s.byte_acc[3:0], h[3:0]};
					r.st.phase    = (s.phase == PH_B_D1) ? PH_B_D2 : PH_B_CHK;
				end
			end
			PH_B_CHK: begin
				// a third hex digit is a syntax error
				if (h[4]) begin
					r.st.err = ST_BAD_BYTE; r.st.phase = PH_IDLE;
				end else begin
					r.emit        = 1'b1;
					r.kind        = KIND_BYTE;
					r.value       = 21'(s.byte_acc);
					r.st.byte_cnt = s.byte_cnt + 5'd1;
					r.st.phase    = PH_B_SEP;
					r.again       = 1'b1;
				end
			end
			PH_SCAN: begin
				if (c == CH_BAR)
					r.st.phase = PH_FB;
			end
			PH_FB: begin
				if (c >= CH_0 && c <= CH_3) begin
					r.st.fb    = $signed({1'b0, c[1:0]});
					r.st.phase = PH_IDLE;
				end else begin
					r.st.err = ST_BAD_FB; r.st.phase = PH_IDLE;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// input register
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			ch_s1 <= ch;
	end

	// chained passes over one character, up to four; at most three are ever needed
	always_comb begin
		p          = '{st: st_q, again: 1'b1, emit: 1'b0, kind: KIND_CP, value: '0};
		emit       = 1'b0;
		emit_kind  = KIND_CP;
		emit_value = '0;
		for (int i = 0; i < 4; i++) begin
			if (p.again) begin
				p = step(p.st, ch_s1);
				if (p.emit) begin
					emit       = 1'b1;
					emit_kind  = p.kind;
					emit_value = p.value;
				end
			end
		end
	end

	// result items for this character
	assign eol = (ch_s1 == CH_NUL);

	always_comb begin
		item_r.kind     = emit_kind;
		item_r.value    = emit_value;
		item_r.status   = ST_OK;
		item_r.cp_cnt   = '0;
		item_r.byte_cnt = '0;
		item_r.fb       = FB_NONE;
		item_r.last     = !eol;
		sum_r.kind      = KIND_SUM;
		sum_r.value     = '0;
		sum_r.status    = p.st.err;
		sum_r.cp_cnt    = p.st.cp_cnt;
		sum_r.byte_cnt  = p.st.byte_cnt;
		sum_r.fb        = (p.st.err != ST_OK) ? FB_NONE : p.st.fb;
		sum_r.last      = 1'b1;
		push.push0      = fire && (emit || eol);
		push.push1      = fire && emit && eol;
		push.r0         = emit ? item_r : sum_r;
		push.r1         = sum_r;
		st_d            = eol ? reset_state() : p.st;
	end

	// parser state, back to reset values at the end of each line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else if (fire) begin
			st_q <= st_d;
		end
	end

endmodule

>>> src/cmlp_outq.sv
// cmlp_outq: small result queue, two writes and one read per cycle
// depends on cmlp_pkg
module cmlp_outq import cmlp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	result_t           mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_q;
	logic [OQ_AW-1:0]  rd_q;
	logic [OQ_AW:0]    cnt_q;
	logic [OQ_AW-1:0]  wr1;
	logic              pop;
	logic [1:0]        npush;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	// accept a parsed item only if both of its possible results fit
	assign room      = (cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign wr1       = wr_q + 1'b1;
	assign npush     = {1'b0, push.push0} + {1'b0, push.push1};

	// entry storage
	always_ff @(posedge clk) begin
		if (push.push0)
			mem_q[wr_q] <= push.r0;
		if (push.push1)
			mem_q[wr1] <= push.r1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_AW'(npush);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (OQ_AW+1)'(npush) - (OQ_AW+1)'(pop);
		end
	end

endmodule

>>> tb/conversion_mapping_line_parser_tb.sv
// self-checking testbench for conversion_mapping_line_parser: directed lines, then random lines
// checked against a behavioral line parser kept in the bench; depends on cmlp_pkg and the rtl
module conversion_mapping_line_parser_tb import cmlp_pkg::*; ();

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_CHARS = 1080;

	// hex letter bases and the top decimal digit
	localparam logic [7:0] LETTER_A_UP = 8'h41;
	localparam logic [7:0] LETTER_A_LO = 8'h61;
	localparam logic [7:0] CH_9        = 8'h39;

	// summary fields of one line, typed in where known up front
	typedef struct {
		bit                typed;
		logic [3:0]        st;
		logic [4:0]        cpc;
		logic [4:0]        bc;
		logic signed [2:0] fb;
	} line_sum_t;

	typedef struct {
		string     text;
		line_sum_t sum;
	} line_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic [7:0]        ch        = 8'h00;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [1:0]        kind;
	logic [20:0]       value;
	logic [3:0]        status;
	logic [4:0]        code_point_count;
	logic [4:0]        byte_count;
	logic signed [2:0] fallback;
	logic              last;

	conversion_mapping_line_parser u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.ch               (ch),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.value            (value),
		.status           (status),
		.code_point_count (code_point_count),
		.byte_count       (byte_count),
		.fallback         (fallback),
		.last             (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line parser state mirrored in the bench
	phase_t            ph;
	logic [20:0]       cp_val;
	logic              cp_sat;
	logic [2:0]        digit_cnt;
	logic [4:0]        cps_seen;
	logic [5:0]        units_seen;
	logic [7:0]        byte_val;
	logic [4:0]        bytes_seen;
	logic [3:0]        line_err;
	logic signed [2:0] fb_sel;

	result_t     line_results_due[$];
	result_t     step_results[$];
	line_sum_t   line_summaries[$];
	logic [7:0]  line_buf[$];
	line_row_t   directed_rows[$];
	int          fail_count  = 0;
	int          burst_left  = 0;
	bit          steady      = 1'b1;
	int          quiet_cycles = 0;

	function automatic void clear_parser();
		ph         = PH_CP_OPEN;
		cp_val     = '0;
		cp_sat     = 1'b0;
		digit_cnt  = '0;
		cps_seen   = '0;
		units_seen = '0;
		byte_val   = '0;
		bytes_seen = '0;
		line_err   = ST_OK;
		fb_sel     = FB_NONE;
	endfunction

	// first error wins, the rest of the line is dropped
	function automatic void stop_line(input logic [3:0] code);
		line_err = code;
		ph       = PH_IDLE;
	endfunction

	function automatic void emit_item(input logic [1:0] k, input logic [20:0] v);
		result_t r;
		r.kind     = k;
		r.value    = v;
		r.status   = ST_OK;
		r.cp_cnt   = '0;
		r.byte_cnt = '0;
		r.fb       = FB_NONE;
		r.last     = 1'b0;
		step_results.push_back(r);
	endfunction

	// advance the parser by one character and queue the results it gives
	task automatic parse_char(input logic [7:0] c);
		int          d;
		int          idx;
		bit          again;
		logic [24:0] grown;
		line_sum_t   ls;
		step_results.delete();
		if (c >= CH_0 && c <= CH_9)
			d = int'(c) - int'(CH_0);
		else if (c >= LETTER_A_LO && c <= LETTER_A_LO + 8'd5)
			d = int'(c) - int'(LETTER_A_LO) + 10;
		else if (c >= LETTER_A_UP && c <= LETTER_A_UP + 8'd5)
			d = int'(c) - int'(LETTER_A_UP) + 10;
		else
			d = -1;
		again = 1'b1;
		for (int round = 0; again && round < 8; round++) begin
			again = 1'b0;
			case (ph)
				// a plus after a code point is optional
				PH_CP_OPEN, PH_CP_SEP: begin
					if (ph == PH_CP_SEP && c == CH_PLUS)
						ph = PH_CP_OPEN;
					else if (c == CH_LT) begin
						if (cps_seen >= MAX_CODE_UNITS_DEF)
							stop_line(ST_TOO_MANY_CPS);
						else
							ph = PH_CP_U;
					end else if (cps_seen == 0)
						stop_line(ST_NO_CPS);
					else if (cps_seen > 1 && units_seen > MAX_CODE_UNITS_DEF)
						stop_line(ST_TOO_MANY_U16);
					else begin
						ph    = PH_WS;
						again = 1'b1;
					end
				end
				PH_CP_U: begin
					if (c == CH_U) begin
						cp_val    = '0;
						cp_sat    = 1'b0;
						digit_cnt = '0;
						ph        = PH_CP_DIG;
					end else
						stop_line(ST_BAD_CP);
				end
				// digits saturate: past the limit the value freezes
				PH_CP_DIG: begin
					if (d >= 0) begin
						if (digit_cnt < 3'd7)
							digit_cnt++;
						if (!cp_sat) begin
							grown = {cp_val, 4'(d)};
							if (grown > CP_LIMIT)
								cp_sat = 1'b1;
							else
								cp_val = grown[20:0];
						end
					end else if (c != CH_GT || digit_cnt == 0)
						stop_line(ST_BAD_CP);
					else if (cp_sat || (cp_val >= SURR_LO && cp_val <= SURR_HI))
						stop_line(ST_CP_RANGE);
					else begin
						emit_item(KIND_CP, cp_val);
						cps_seen++;
						units_seen += (cp_val > BMP_MAX) ? 6'd2 : 6'd1;
						ph = PH_CP_SEP;
					end
				end
				PH_WS: begin
					if (c != CH_SP && c != CH_TAB) begin
						ph    = PH_B_OPEN;
						again = 1'b1;
					end
				end
				PH_B_OPEN, PH_B_SEP: begin
					if (ph == PH_B_SEP && c == CH_PLUS)
						ph = PH_B_OPEN;
					else if (c == CH_BSL) begin
						if (bytes_seen >= MAX_BYTES_DEF)
							stop_line(ST_TOO_MANY_B);
						else
							ph = PH_B_X;
					end else if (bytes_seen == 0)
						stop_line(ST_NO_BYTES);
					else begin
						ph    = PH_SCAN;
						again = 1'b1;
					end
				end
				PH_B_X: begin
					if (c == CH_X) begin
						byte_val = '0;
						ph       = PH_B_D1;
					end else
						stop_line(ST_BAD_BYTE);
				end
				PH_B_D1, PH_B_D2: begin
					if (d < 0)
						stop_line(ST_BAD_BYTE);
					else begin
						byte_val = {byte_val[3:0], 4'(d)};
						ph       = (ph == PH_B_D1) ? PH_B_D2 : PH_B_CHK;
					end
				end
				// a byte is final once a non-digit follows it
				PH_B_CHK: begin
					if (d >= 0)
						stop_line(ST_BAD_BYTE);
					else begin
						emit_item(KIND_BYTE, {13'd0, byte_val});
						bytes_seen++;
						ph    = PH_B_SEP;
						again = 1'b1;
					end
				end
				PH_SCAN: begin
					if (c == CH_BAR)
						ph = PH_FB;
				end
				PH_FB: begin
					if (c >= CH_0 && c <= CH_3) begin
						fb_sel = $signed(3'(c - CH_0));
						ph     = PH_IDLE;
					end else
						stop_line(ST_BAD_FB);
				end
				default: ;
			endcase
		end
		// line end: summary, then back to the start of a line
		if (c == CH_NUL) begin
			emit_item(KIND_SUM, '0);
			idx = step_results.size() - 1;
			step_results[idx].status   = line_err;
			step_results[idx].cp_cnt   = cps_seen;
			step_results[idx].byte_cnt = bytes_seen;
			step_results[idx].fb       = (line_err != ST_OK) ? FB_NONE : fb_sel;
			if (line_summaries.size() != 0) begin
				ls = line_summaries.pop_front();
				if (ls.typed) begin
					step_results[idx].status   = ls.st;
					step_results[idx].cp_cnt   = ls.cpc;
					step_results[idx].byte_cnt = ls.bc;
					step_results[idx].fb       = ls.fb;
				end
			end
			clear_parser();
		end
		if (step_results.size() != 0)
			step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i])
			line_results_due.push_back(step_results[i]);
	endtask

	function automatic void put_ch(input logic [7:0] c);
		line_buf.push_back(c);
	endfunction

	// hex digits with leading zeros and mixed letter case
	function automatic void put_hex(input logic [31:0] v, input int ndig);
		logic [3:0] nib;
		for (int i = ndig - 1; i >= 0; i--) begin
			nib = 4'(v >> (4 * i));
			if (nib < 4'd10)
				line_buf.push_back(CH_0 + 8'(nib));
			else
				line_buf.push_back(($urandom_range(0, 1) ? LETTER_A_UP : LETTER_A_LO)
					+ 8'(nib) - 8'd10);
		end
	endfunction

	function automatic string repeat_text(input string s, input int n);
		string r;
		r = "";
		repeat (n) r = {r, s};
		return r;
	endfunction

	function automatic void add_row(input string text, input bit typed, input logic [3:0] st,
		input logic [4:0] cpc, input logic [4:0] bc, input logic signed [2:0] fb);
		line_row_t row;
		row.text      = text;
		row.sum.typed = typed;
		row.sum.st    = st;
		row.sum.cpc   = cpc;
		row.sum.bc    = bc;
		row.sum.fb    = fb;
		directed_rows.push_back(row);
	endfunction

	// offer one character, wait for it to go, then maybe pause between bursts
	task automatic send_char(input logic [7:0] c);
		in_valid <= 1'b1;
		ch       <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		else if (!steady) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	task automatic send_line(input line_sum_t s);
		line_summaries.push_back(s);
		steady = ($urandom_range(0, 3) == 0);
		foreach (line_buf[i])
			send_char(line_buf[i]);
		send_char(CH_NUL);
	endtask

	// receiver stalls: modes switch when a random countdown runs out
	int         stall_left = 0;
	int         stall_mode = 0;
	logic [7:0] stall_mask = 8'hFF;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 256);
			stall_mask <= 8'($urandom_range(1, 255));
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= stall_mask[stall_left[2:0]];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result check first, then prediction of the item taken at this edge
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_results_due.size() == 0) begin
				$error("result with nothing due: kind %0d value 0x%0h", kind, value);
				fail_count++;
			end else begin
				want = line_results_due.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (value !== want.value) begin
					$error("value: expected 0x%0h, got 0x%0h", want.value, value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (code_point_count !== want.cp_cnt) begin
					$error("code_point_count: expected %0d, got %0d", want.cp_cnt,
						code_point_count);
					fail_count++;
				end
				if (byte_count !== want.byte_cnt) begin
					$error("byte_count: expected %0d, got %0d", want.byte_cnt, byte_count);
					fail_count++;
				end
				if (fallback !== want.fb) begin
					$error("fallback: expected %0d, got %0d", want.fb, fallback);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			parse_char(ch);
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int         sent_chars;
		int         pick;
		int         ncp;
		int         nbytes;
		int         ndig;
		logic [31:0] cp;
		line_sum_t  free_sum;

		clear_parser();
		free_sum.typed = 1'b0;
		free_sum.st    = ST_OK;
		free_sum.cpc   = '0;
		free_sum.bc    = '0;
		free_sum.fb    = FB_NONE;

		// directed lines: summary typed in where it is plain
		add_row("<U41>\\x42 |0", 1'b1, ST_OK, 5'd1, 5'd1, 3'sd0);
		add_row("", 1'b1, ST_NO_CPS, 5'd0, 5'd0, FB_NONE);
		add_row("<U10FFFF>\\xFF|3", 1'b1, ST_OK, 5'd1, 5'd1, 3'sd3);
		add_row("<U0>\\x00", 1'b1, ST_OK, 5'd1, 5'd1, FB_NONE);
		add_row("<U110000>\\x00", 1'b1, ST_CP_RANGE, 5'd0, 5'd0, FB_NONE);
		add_row("<UD800>\\x41", 1'b1, ST_CP_RANGE, 5'd0, 5'd0, FB_NONE);
		add_row("<UDFFF>\\x41", 1'b1, ST_CP_RANGE, 5'd0, 5'd0, FB_NONE);
		add_row("<UD7FF>+<UE000>\\xff", 1'b1, ST_OK, 5'd2, 5'd1, FB_NONE);
		add_row("<U>\\x41", 1'b1, ST_BAD_CP, 5'd0, 5'd0, FB_NONE);
		add_row("<u41>\\x41", 1'b1, ST_BAD_CP, 5'd0, 5'd0, FB_NONE);
		add_row("<U0x41>\\x41", 1'b1, ST_BAD_CP, 5'd0, 5'd0, FB_NONE);
		add_row(" <U41>\\x41", 1'b1, ST_NO_CPS, 5'd0, 5'd0, FB_NONE);
		add_row({repeat_text("<U41>", 19), "\\x41"}, 1'b1, ST_OK, 5'd19, 5'd1, FB_NONE);
		add_row({repeat_text("<U41>", 20), "\\x41"}, 1'b1, ST_TOO_MANY_CPS, 5'd19, 5'd0,
			FB_NONE);
		add_row({repeat_text("<U10000>", 10), "\\x41"}, 1'b1, ST_TOO_MANY_U16, 5'd10, 5'd0,
			FB_NONE);
		add_row({"<U41>", repeat_text("\\x41", 31)}, 1'b1, ST_OK, 5'd1, 5'd31, FB_NONE);
		add_row({"<U41>", repeat_text("\\x41", 32)}, 1'b1, ST_TOO_MANY_B, 5'd1, 5'd31,
			FB_NONE);
		add_row("<U41>", 1'b1, ST_NO_BYTES, 5'd1, 5'd0, FB_NONE);
		add_row("<U41>\\x4", 1'b1, ST_BAD_BYTE, 5'd1, 5'd0, FB_NONE);
		add_row("<U41>\\x123", 1'b1, ST_BAD_BYTE, 5'd1, 5'd0, FB_NONE);
		add_row("<U41>\\x 12", 1'b1, ST_BAD_BYTE, 5'd1, 5'd0, FB_NONE);
		add_row("<U41>\\x41|", 1'b1, ST_BAD_FB, 5'd1, 5'd1, FB_NONE);
		add_row("<U41>\\x41|4", 1'b1, ST_BAD_FB, 5'd1, 5'd1, FB_NONE);
		add_row("x<U41>\\x41|0", 1'b1, ST_NO_CPS, 5'd0, 5'd0, FB_NONE);
		add_row("<U41>\\x41|0\377\200", 1'b1, ST_OK, 5'd1, 5'd1, 3'sd0);
		add_row("<U1F600>+<U41> \\x41+\\x42\\x43 |1 z", 1'b0, ST_OK, 5'd0, 5'd0, FB_NONE);
		add_row("<U0000000000041>\t \\x41\tab|2c", 1'b0, ST_OK, 5'd0, 5'd0, FB_NONE);
		add_row("<U41>+\\x41 + \\x42", 1'b0, ST_OK, 5'd0, 5'd0, FB_NONE);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			line_buf.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++)
				line_buf.push_back(directed_rows[r].text[i]);
			send_line(directed_rows[r].sum);
		end

		// random lines: mostly well formed, some corrupted, some pure noise
		sent_chars = 0;
		while (sent_chars < RANDOM_CHARS) begin
			line_buf.delete();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 12)) put_ch(8'($urandom_range(1, 255)));
			end else begin
				ncp = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 3);
				for (int i = 0; i < ncp; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 40)
						cp = $urandom_range(0, 'h7F);
					else if (pick < 70)
						cp = $urandom_range(0, 'hFFFF);
					else if (pick < 90)
						cp = $urandom_range('h10000, 'h10FFFF);
					else if (pick < 95)
						cp = $urandom_range('hD800, 'hDFFF);
					else
						cp = $urandom_range('h110000, 'hFFFFFF);
					ndig = 1;
					while ((cp >> (4 * ndig)) != 0)
						ndig++;
					ndig += $urandom_range(0, 2);
					if ($urandom_range(0, 49) == 0)
						ndig = 0;
					put_ch(CH_LT);
					put_ch(CH_U);
					put_hex(cp, ndig);
					put_ch(CH_GT);
					if ($urandom_range(0, (i == ncp - 1) ? 9 : 1) == 0)
						put_ch(CH_PLUS);
				end
				repeat ($urandom_range(0, 2)) put_ch($urandom_range(0, 1) ? CH_SP : CH_TAB);
				nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(29, 33)
					: $urandom_range(1, 4);
				for (int i = 0; i < nbytes; i++) begin
					put_ch(CH_BSL);
					put_ch(CH_X);
					pick = $urandom_range(0, 99);
					put_hex($urandom_range(0, 'hFFF), (pick < 3) ? 3 : (pick < 6) ? 1 : 2);
					if ($urandom_range(0, 1))
						put_ch(CH_PLUS);
				end
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 4)) put_ch(8'($urandom_range(8'h20, 8'h7E)));
				if ($urandom_range(0, 9) < 7) begin
					put_ch(CH_BAR);
					pick = $urandom_range(0, 99);
					if (pick < 85)
						put_ch(CH_0 + 8'($urandom_range(0, 3)));
					else if (pick < 95)
						put_ch(8'($urandom_range(1, 255)));
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 3)) put_ch(8'($urandom_range(1, 255)));
				end
				// one corrupted character now and then
				if ($urandom_range(0, 6) == 0)
					line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(1, 255));
			end
			sent_chars += line_buf.size() + 1;
			send_line(free_sum);
		end

		// drain: wait for every due result, then report
		in_valid <= 1'b0;
		@(posedge clk);
		while (line_results_due.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
